>>> rtl/core/svq_pkg.sv
// ----------------------------------------------------------------------------
// svq_pkg
// Shared types, codes and sizes for the split virtqueue device side.
// ----------------------------------------------------------------------------
package svq_pkg;

  localparam int QUEUE_DEPTH  = 256;
  localparam int SLOT_W       = $clog2(QUEUE_DEPTH);
  localparam int SIZE_W       = 9;
  localparam int MAX_SEGMENTS = 16;
  localparam int SEG_W        = 5;

  typedef enum logic [2:0] {
    CMD_WR_DESC   = 3'd0,
    CMD_WR_AVAIL  = 3'd1,
    CMD_SET_AVAIL = 3'd2,
    CMD_FETCH     = 3'd3,
    CMD_RETURN    = 3'd4,
    CMD_POLL      = 3'd5,
    CMD_SUPPRESS  = 3'd6,
    CMD_RD_USED   = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_CLOSED      = 3'd1,
    ST_NO_BUF      = 3'd2,
    ST_NOT_VALID   = 3'd3,
    ST_TOO_BIG     = 3'd4,
    ST_AVAIL_RANGE = 3'd5,
    ST_HEAD_RANGE  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    CFG_ENABLE  = 2'd0,
    CFG_SIZE    = 2'd1,
    CFG_MAX_IN  = 2'd2,
    CFG_MAX_OUT = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_MOD_WAIT, S_HEAD_CHK, S_DESC_CHK, S_FINAL
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_ACCEPT, OP_WR_DESC, OP_WR_AVAIL, OP_SET_AVAIL, OP_MOD_AVAIL,
    OP_MOD_USED, OP_RD_AVAIL, OP_TAKE_HEAD, OP_SEG, OP_RET_WR, OP_POLL,
    OP_SUPPRESS, OP_RD_USED
  } dp_op_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] index;
    logic [63:0] buf_addr;
    logic [31:0] buf_len;
    logic [1:0]  desc_bits;
    logic [15:0] next_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [15:0]      head_id;
    logic             writable;
    logic [63:0]      seg_addr;
    logic [31:0]      seg_len;
    logic [SEG_W-1:0] in_count;
    logic [SEG_W-1:0] out_count;
    logic [31:0]      in_total;
    logic [31:0]      out_total;
    logic [15:0]      count;
    logic             no_notify;
    logic             last;
  } out_item_t;

  typedef struct packed {
    dp_op_t  op;
    logic    push_final;
    status_e status;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_e command;
    logic enabled;
    logic idx_big;
    logic idx_ge_size;
    logic pend_zero;
    logic pend_over;
    logic mod_busy;
    logic head_ge_size;
    logic lim_hit;
    logic has_next;
    logic link_ge_size;
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/core/svq_if.sv
// ----------------------------------------------------------------------------
// svq_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface svq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [15:0] index;
  logic [63:0] buf_addr;
  logic [31:0] buf_len;
  logic [1:0]  desc_bits;
  logic [15:0] next_index;
  modport source (output valid, command, index, buf_addr, buf_len, desc_bits, next_index,
                  input ready);
  modport sink (input valid, command, index, buf_addr, buf_len, desc_bits, next_index,
                output ready);
endinterface

interface svq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] head_id;
  logic        writable;
  logic [63:0] seg_addr;
  logic [31:0] seg_len;
  logic [4:0]  in_count;
  logic [4:0]  out_count;
  logic [31:0] in_total;
  logic [31:0] out_total;
  logic [15:0] count;
  logic        no_notify;
  logic        last;
  modport source (output valid, status, head_id, writable, seg_addr, seg_len, in_count,
                  out_count, in_total, out_total, count, no_notify, last, input ready);
  modport sink (input valid, status, head_id, writable, seg_addr, seg_len, in_count,
                out_count, in_total, out_total, count, no_notify, last, output ready);
endinterface

>>> rtl/core/svq_mod.sv
// ----------------------------------------------------------------------------
// svq_mod
// Restoring remainder unit: 16-bit index modulo ring size, one bit a cycle.
// ----------------------------------------------------------------------------
module svq_mod import svq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [15:0]       dividend,
  input  logic [SIZE_W-1:0] divisor,
  output logic              busy,
  output logic [SLOT_W-1:0] rem
);

  logic              busy_r, busy_nxt;
  logic [3:0]        step_r, step_nxt;
  logic [15:0]       dvd_r, dvd_nxt;
  logic [SLOT_W-1:0] rem_r, rem_nxt;
  logic [SIZE_W-1:0] trial;

  always_comb begin
    trial    = {rem_r, dvd_r[15]};
    busy_nxt = busy_r;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = 4'd15;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // subtract where the trial remainder reaches the divisor
      if (trial >= divisor) rem_nxt = SLOT_W'(trial - divisor);
      else                  rem_nxt = SLOT_W'(trial);
      dvd_nxt  = {dvd_r[14:0], 1'b0};
      step_nxt = step_r - 4'd1;
      if (step_r == 4'd0) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    step_r <= step_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
  end

  assign busy = busy_r;
  assign rem  = rem_r;

endmodule

>>> rtl/core/svq_dp.sv
// ----------------------------------------------------------------------------
// svq_dp
// Datapath: rings, descriptor table, indices, chain totals and result register.
// ----------------------------------------------------------------------------
module svq_dp import svq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  ctrl_cmd_t  cmd,
  output dp_stat_t   stat,
  input  in_item_t   in_item,
  input  logic       cfg_we,
  input  cfg_reg_e   cfg_index,
  input  logic [8:0] cfg_wdata,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item
);

  typedef struct packed {
    logic [63:0] addr;
    logic [31:0] len;
    logic [1:0]  bits;
    logic [15:0] link;
  } desc_t;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] len;
  } used_t;

  desc_t       desc_mem  [QUEUE_DEPTH];
  logic [15:0] avail_mem [QUEUE_DEPTH];
  used_t       used_mem  [QUEUE_DEPTH];
  desc_t       desc_q;
  logic [15:0] avail_q;
  used_t       used_q;

  logic              en_r;
  logic [8:0]        size_cfg_r;
  logic [SEG_W-1:0]  max_in_r, max_out_r;
  in_item_t          item_r;
  logic [15:0]       avail_idx_r, last_seen_r, used_idx_r;
  logic              flag_r;
  logic [15:0]       head_r;
  logic [SEG_W-1:0]  inc_r, outc_r;
  logic [31:0]       int_r, outt_r;
  logic              out_valid_r;
  out_item_t         out_r, out_nxt;

  logic [SIZE_W-1:0] size;
  logic [SEG_W-1:0]  lim_in, lim_out;
  logic [15:0]       pend;
  logic              mod_start, mod_busy;
  logic [15:0]       mod_dvd;
  logic [SLOT_W-1:0] mod_rem;
  logic              out_free, st_ok;
  logic [SEG_W-1:0]  inc_seg, outc_seg;
  logic [31:0]       int_seg, outt_seg;

  assign size    = (size_cfg_r == '0) ? SIZE_W'(1) :
                   (size_cfg_r > SIZE_W'(QUEUE_DEPTH)) ? SIZE_W'(QUEUE_DEPTH) : size_cfg_r;
  assign lim_in  = (max_in_r  > SEG_W'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS) : max_in_r;
  assign lim_out = (max_out_r > SEG_W'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS) : max_out_r;
  assign pend    = avail_idx_r - last_seen_r;
  assign out_free = !out_valid_r || out_ready;

  assign mod_start = (cmd.op == OP_MOD_AVAIL) || (cmd.op == OP_MOD_USED);
  assign mod_dvd   = (cmd.op == OP_MOD_USED) ? used_idx_r : last_seen_r;

  svq_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dvd),
    .divisor  (size),
    .busy     (mod_busy),
    .rem      (mod_rem)
  );

  always_comb begin
    stat.command      = cmd_e'(item_r.command);
    stat.enabled      = en_r;
    stat.idx_big      = item_r.index >= 16'(QUEUE_DEPTH);
    stat.idx_ge_size  = item_r.index >= 16'(size);
    stat.pend_zero    = pend == '0;
    stat.pend_over    = pend > 16'(size);
    stat.mod_busy     = mod_busy;
    stat.head_ge_size = avail_q >= 16'(size);
    stat.lim_hit      = desc_q.bits[1] ? (outc_r >= lim_out) : (inc_r >= lim_in);
    stat.has_next     = desc_q.bits[0];
    stat.link_ge_size = desc_q.link >= 16'(size);
    stat.out_free     = out_free;
  end

  // memories: one write and one registered read per cycle each
  always_ff @(posedge clk) begin
    if (cmd.op == OP_WR_DESC) begin
      desc_mem[item_r.index[SLOT_W-1:0]] <= '{item_r.buf_addr, item_r.buf_len,
                                             item_r.desc_bits, item_r.next_index};
    end
    if (cmd.op == OP_TAKE_HEAD) desc_q <= desc_mem[avail_q[SLOT_W-1:0]];
    else if (cmd.op == OP_SEG)  desc_q <= desc_mem[desc_q.link[SLOT_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WR_AVAIL) avail_mem[item_r.index[SLOT_W-1:0]] <= item_r.next_index;
    if (cmd.op == OP_RD_AVAIL) avail_q <= avail_mem[mod_rem];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_RET_WR) used_mem[mod_rem] <= '{item_r.index[15:0], item_r.buf_len};
    if (cmd.op == OP_RD_USED) used_q <= used_mem[item_r.index[SLOT_W-1:0]];
  end

  assign inc_seg  = desc_q.bits[1] ? inc_r  : inc_r + SEG_W'(1);
  assign outc_seg = desc_q.bits[1] ? outc_r + SEG_W'(1) : outc_r;
  assign int_seg  = desc_q.bits[1] ? int_r  : int_r + desc_q.len;
  assign outt_seg = desc_q.bits[1] ? outt_r + desc_q.len : outt_r;
  assign st_ok    = cmd.status == ST_OK;

  always_comb begin
    out_nxt           = '0;
    out_nxt.no_notify = flag_r;
    out_nxt.in_count  = inc_r;
    out_nxt.out_count = outc_r;
    out_nxt.in_total  = int_r;
    out_nxt.out_total = outt_r;
    if (cmd.op == OP_SEG) begin
      out_nxt.head_id   = head_r;
      out_nxt.writable  = desc_q.bits[1];
      out_nxt.seg_addr  = desc_q.addr;
      out_nxt.seg_len   = desc_q.len;
      out_nxt.in_count  = inc_seg;
      out_nxt.out_count = outc_seg;
      out_nxt.in_total  = int_seg;
      out_nxt.out_total = outt_seg;
    end else begin
      out_nxt.status = cmd.status;
      out_nxt.last   = 1'b1;
      unique case (cmd_e'(item_r.command))
        CMD_FETCH: begin
          if (st_ok || cmd.status == ST_NOT_VALID || cmd.status == ST_TOO_BIG) begin
            out_nxt.count = pend;
          end
          if (st_ok || cmd.status == ST_NOT_VALID || cmd.status == ST_TOO_BIG ||
              cmd.status == ST_HEAD_RANGE) begin
            out_nxt.head_id = head_r;
          end
        end
        CMD_RETURN: begin
          if (st_ok) begin
            out_nxt.head_id = item_r.index;
            out_nxt.count   = used_idx_r;
          end
        end
        CMD_POLL: out_nxt.count = pend;
        CMD_RD_USED: begin
          out_nxt.count = used_idx_r;
          if (st_ok) begin
            out_nxt.head_id = used_q.id;
            out_nxt.seg_len = used_q.len;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= 1'b0;
      size_cfg_r  <= 9'd256;
      max_in_r    <= SEG_W'(MAX_SEGMENTS);
      max_out_r   <= SEG_W'(MAX_SEGMENTS);
      avail_idx_r <= '0;
      last_seen_r <= '0;
      used_idx_r  <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ENABLE:  en_r       <= cfg_wdata[0];
          CFG_SIZE:    size_cfg_r <= cfg_wdata;
          CFG_MAX_IN:  max_in_r   <= cfg_wdata[SEG_W-1:0];
          CFG_MAX_OUT: max_out_r  <= cfg_wdata[SEG_W-1:0];
        endcase
      end
      unique case (cmd.op)
        OP_SET_AVAIL: avail_idx_r <= item_r.index;
        OP_TAKE_HEAD: last_seen_r <= last_seen_r + 16'd1;
        OP_RET_WR:    used_idx_r  <= used_idx_r + 16'd1;
        OP_POLL:      flag_r      <= pend != '0;
        OP_SUPPRESS:  flag_r      <= flag_r | en_r;
        default: ;
      endcase
      if (cmd.op == OP_SEG || cmd.push_final) out_valid_r <= 1'b1;
      else if (out_ready)                     out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_ACCEPT) begin
      item_r <= in_item;
      head_r <= '0;
      inc_r  <= '0;
      outc_r <= '0;
      int_r  <= '0;
      outt_r <= '0;
    end
    if (cmd.op == OP_TAKE_HEAD) head_r <= avail_q;
    if (cmd.op == OP_SEG) begin
      inc_r  <= inc_seg;
      outc_r <= outc_seg;
      int_r  <= int_seg;
      outt_r <= outt_seg;
    end
    if (cmd.op == OP_SEG || cmd.push_final) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

>>> rtl/core/svq_ctrl.sv
// ----------------------------------------------------------------------------
// svq_ctrl
// Command sequencer: decodes a beat, steps the chain walk, closes the result.
// ----------------------------------------------------------------------------
module svq_ctrl import svq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t  state_r, state_nxt;
  status_e status_r, status_nxt;

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        state_nxt  = S_FINAL;
        status_nxt = ST_OK;
        unique case (stat.command)
          CMD_WR_DESC, CMD_WR_AVAIL, CMD_RD_USED: begin
            if (stat.idx_big) status_nxt = ST_NOT_VALID;
          end
          CMD_FETCH: begin
            priority if (!stat.enabled) status_nxt = ST_CLOSED;
            else if (stat.pend_over)    status_nxt = ST_AVAIL_RANGE;
            else if (stat.pend_zero)    status_nxt = ST_NO_BUF;
            else                        state_nxt  = S_MOD_WAIT;
          end
          CMD_RETURN: begin
            priority if (!stat.enabled) status_nxt = ST_CLOSED;
            else if (stat.idx_ge_size)  status_nxt = ST_NOT_VALID;
            else                        state_nxt  = S_MOD_WAIT;
          end
          default: ;
        endcase
      end
      S_MOD_WAIT: begin
        if (!stat.mod_busy) begin
          state_nxt = (stat.command == CMD_FETCH) ? S_HEAD_CHK : S_FINAL;
        end
      end
      S_HEAD_CHK: begin
        if (stat.head_ge_size) begin
          state_nxt  = S_FINAL;
          status_nxt = ST_HEAD_RANGE;
        end else begin
          state_nxt  = S_DESC_CHK;
        end
      end
      S_DESC_CHK: begin
        priority if (stat.lim_hit) begin
          state_nxt  = S_FINAL;
          status_nxt = ST_TOO_BIG;
        end else if (stat.out_free) begin
          if (!stat.has_next) begin
            state_nxt = S_FINAL;
          end else if (stat.link_ge_size) begin
            state_nxt  = S_FINAL;
            status_nxt = ST_NOT_VALID;
          end
        end
      end
      S_FINAL: if (stat.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '{op: OP_NONE, push_final: 1'b0, status: status_r};
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_ACCEPT;
      end
      S_DECODE: begin
        unique case (stat.command)
          CMD_WR_DESC:   if (!stat.idx_big) cmd.op = OP_WR_DESC;
          CMD_WR_AVAIL:  if (!stat.idx_big) cmd.op = OP_WR_AVAIL;
          CMD_SET_AVAIL: cmd.op = OP_SET_AVAIL;
          CMD_FETCH: begin
            if (stat.enabled && !stat.pend_over && !stat.pend_zero) cmd.op = OP_MOD_AVAIL;
          end
          CMD_RETURN:    if (stat.enabled && !stat.idx_ge_size) cmd.op = OP_MOD_USED;
          CMD_POLL:      cmd.op = OP_POLL;
          CMD_SUPPRESS:  cmd.op = OP_SUPPRESS;
          CMD_RD_USED:   if (!stat.idx_big) cmd.op = OP_RD_USED;
        endcase
      end
      S_MOD_WAIT: begin
        if (!stat.mod_busy) cmd.op = (stat.command == CMD_FETCH) ? OP_RD_AVAIL : OP_RET_WR;
      end
      S_HEAD_CHK: cmd.op = OP_TAKE_HEAD;
      S_DESC_CHK: if (!stat.lim_hit && stat.out_free) cmd.op = OP_SEG;
      S_FINAL:    cmd.push_final = stat.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  a_push_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.push_final && cmd.op == OP_SEG))
    else $error("segment and closing result pushed together");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_final || cmd.op == OP_SEG) |-> stat.out_free)
    else $error("result pushed over an untaken result");

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && in_valid) |=> state_r == S_DECODE)
    else $error("accepted beat not decoded");

  a_walk_only_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DESC_CHK) |-> stat.command == CMD_FETCH)
    else $error("chain walk outside a fetch");

endmodule

>>> rtl/core/split_virtqueue_device_side_top.sv
// ----------------------------------------------------------------------------
// split_virtqueue_device_side_top
// Device side of a split virtqueue: descriptor table, avail and used rings.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries command beats (write descriptor, write avail slot, set avail
//   index, fetch, return used, poll, suppress, read used slot). out_ch carries
//   result beats; every command closes with one beat that has last set, and a
//   fetch first sends one beat per gathered segment.
//   cfg_we/cfg_index/cfg_wdata write the ring setup registers; write them only
//   while no command is in flight.
// Sequencing:
//   One command at a time. Writes, set, poll and suppress pass from accept
//   through decode and the closing state into the result register. The
//   slot of a return-used is the used index modulo ring size, from a
//   one-bit-a-cycle remainder unit. A fetch takes its avail slot from the
//   same unit, then walks the chain on the descriptor table's single read port.
// Reset (rst_n low, synchronous): indices, no-notify and the registers return
//   to their defaults; ring and table contents stay undefined until written.
// Stall: a result beat waits in the output register; the chain walk holds
//   while that register is full and out_ch.ready is low.
// ----------------------------------------------------------------------------
module split_virtqueue_device_side_top import svq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  svq_in_if.sink     in_ch,
  svq_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_wdata
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  in_item_t  in_item;
  out_item_t out_item;

  // gather the command beat
  assign in_item = '{in_ch.command, in_ch.index, in_ch.buf_addr, in_ch.buf_len,
                     in_ch.desc_bits, in_ch.next_index};

  svq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  svq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_reg_e'(cfg_index)),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  // spread the result register over the channel fields
  assign out_ch.status    = out_item.status;
  assign out_ch.head_id   = out_item.head_id;
  assign out_ch.writable  = out_item.writable;
  assign out_ch.seg_addr  = out_item.seg_addr;
  assign out_ch.seg_len   = out_item.seg_len;
  assign out_ch.in_count  = out_item.in_count;
  assign out_ch.out_count = out_item.out_count;
  assign out_ch.in_total  = out_item.in_total;
  assign out_ch.out_total = out_item.out_total;
  assign out_ch.count     = out_item.count;
  assign out_ch.no_notify = out_item.no_notify;
  assign out_ch.last      = out_item.last;

endmodule

>>> verif/split_virtqueue_device_side_top_tb.sv
// ----------------------------------------------------------------------------
// split_virtqueue_device_side_top_tb
// Self-checking bench for the split virtqueue device side. Command beats are
// driven from a queue with random gaps; every accepted command is run through
// a local ring model, and result beats are checked field by field in order.
// ----------------------------------------------------------------------------
module split_virtqueue_device_side_top_tb;
  import svq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 40;   // extra wait once nothing is left in flight
  localparam int HOLD_CYCLES = 400;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [8:0] cfg_wdata;

  svq_in_if  in_ch ();
  svq_out_if out_ch ();

  split_virtqueue_device_side_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Ring model: tables, indices and registers as the block should hold them
  // --------------------------------------------------------------------------
  logic [63:0] m_addr  [QUEUE_DEPTH];
  logic [31:0] m_len   [QUEUE_DEPTH];
  logic [1:0]  m_bits  [QUEUE_DEPTH];
  logic [15:0] m_link  [QUEUE_DEPTH];
  logic [15:0] m_avail_ring [QUEUE_DEPTH];
  logic [15:0] m_used_id    [QUEUE_DEPTH];
  logic [31:0] m_used_len   [QUEUE_DEPTH];
  bit          used_written [QUEUE_DEPTH];
  logic [15:0] m_avail_idx, m_seen_idx, m_used_idx;
  logic        m_suppress;
  logic        m_enabled;
  logic [8:0]  m_size;
  logic [4:0]  m_max_in, m_max_out;

  in_item_t  pending_cmds [$];
  out_item_t expected_beats [$];
  int        errors = 0;
  int        cyc = 0;
  bit        calm = 1'b0;      // phase with no idling on either side
  int        hold_req = 0;     // bump to ask the receiver for a long hold-off

  function automatic int unsigned ring_span();
    if (m_size == 9'd0) return 1;
    if (m_size > QUEUE_DEPTH) return QUEUE_DEPTH;
    return m_size;
  endfunction

  function automatic int unsigned seg_cap(logic [4:0] v);
    return (v > MAX_SEGMENTS) ? MAX_SEGMENTS : v;
  endfunction

  // Work out the result beats of one command and advance the ring model.
  task automatic run_ring_command(in_item_t it);
    out_item_t   r;
    int unsigned sz, pend, cur, lim_in, lim_out;
    logic [15:0] h, head, cnt, slot;
    logic [31:0] slen, in_tot, out_tot;
    logic [4:0]  inc, outc;
    status_e     st;
    bit          more, wr;
    sz = ring_span();
    st = ST_OK;
    head = '0; cnt = '0; slen = '0; inc = '0; outc = '0; in_tot = '0; out_tot = '0;
    case (cmd_e'(it.command))
      CMD_WR_DESC: begin
        if (it.index < QUEUE_DEPTH) begin
          m_addr[it.index] = it.buf_addr;
          m_len[it.index]  = it.buf_len;
          m_bits[it.index] = it.desc_bits;
          m_link[it.index] = it.next_index;
        end else st = ST_NOT_VALID;
      end
      CMD_WR_AVAIL: begin
        if (it.index < QUEUE_DEPTH) m_avail_ring[it.index] = it.next_index;
        else st = ST_NOT_VALID;
      end
      CMD_SET_AVAIL: m_avail_idx = it.index;
      CMD_FETCH: begin
        pend = 16'(m_avail_idx - m_seen_idx);
        if (!m_enabled) st = ST_CLOSED;
        else if (pend > sz) st = ST_AVAIL_RANGE;
        else if (pend == 0) st = ST_NO_BUF;
        else begin
          h = m_avail_ring[m_seen_idx % sz];
          m_seen_idx = m_seen_idx + 16'd1;
          head = h;
          lim_in = seg_cap(m_max_in);
          lim_out = seg_cap(m_max_out);
          // a head past the ring consumes the slot but leaves count at zero
          if (h >= sz) st = ST_HEAD_RANGE;
          else begin
            cur = h;
            more = 1'b1;
            while (more) begin
              if (cur >= sz) begin
                st = ST_NOT_VALID;
                break;
              end
              wr = m_bits[cur][1];
              if (wr) begin
                if (outc >= lim_out) begin
                  st = ST_TOO_BIG;
                  break;
                end
                outc++;
                out_tot += m_len[cur];
              end else begin
                if (inc >= lim_in) begin
                  st = ST_TOO_BIG;
                  break;
                end
                inc++;
                in_tot += m_len[cur];
              end
              r = '0;
              r.head_id = head;
              r.writable = wr;
              r.seg_addr = m_addr[cur];
              r.seg_len = m_len[cur];
              r.in_count = inc;
              r.out_count = outc;
              r.in_total = in_tot;
              r.out_total = out_tot;
              r.no_notify = m_suppress;
              expected_beats.push_back(r);
              more = m_bits[cur][0];
              cur = m_link[cur];
            end
            cnt = m_avail_idx - m_seen_idx;
          end
        end
      end
      CMD_RETURN: begin
        if (!m_enabled) st = ST_CLOSED;
        else if (it.index >= sz) st = ST_NOT_VALID;
        else begin
          slot = m_used_idx % sz;
          m_used_id[slot] = it.index;
          m_used_len[slot] = it.buf_len;
          used_written[slot] = 1'b1;
          m_used_idx = m_used_idx + 16'd1;
          head = it.index;
          cnt = m_used_idx;
        end
      end
      CMD_POLL: begin
        cnt = m_avail_idx - m_seen_idx;
        m_suppress = (cnt != 0);
      end
      CMD_SUPPRESS: if (m_enabled) m_suppress = 1'b1;
      default: begin
        if (it.index < QUEUE_DEPTH) begin
          head = m_used_id[it.index];
          slen = m_used_len[it.index];
        end else st = ST_NOT_VALID;
        cnt = m_used_idx;
      end
    endcase
    r = '0;
    r.status = st;
    r.head_id = head;
    r.seg_len = slen;
    r.in_count = inc;
    r.out_count = outc;
    r.in_total = in_tot;
    r.out_total = out_tot;
    r.count = cnt;
    r.no_notify = m_suppress;
    r.last = 1'b1;
    expected_beats.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("[%0d] mismatch %s: got %h, want %h", cyc, what, got, want);
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Driver: one beat at a time from the pending queue, random gap before each
  // --------------------------------------------------------------------------
  int send_gap = 0;

  always @(posedge clk) begin
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("split_virtqueue_device_side_top_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    in_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        run_ring_command('{in_ch.command, in_ch.index, in_ch.buf_addr, in_ch.buf_len,
                           in_ch.desc_bits, in_ch.next_index});
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          nxt = pending_cmds.pop_front();
          in_ch.command    <= nxt.command;
          in_ch.index      <= nxt.index;
          in_ch.buf_addr   <= nxt.buf_addr;
          in_ch.buf_len    <= nxt.buf_len;
          in_ch.desc_bits  <= nxt.desc_bits;
          in_ch.next_index <= nxt.next_index;
          in_ch.valid      <= 1'b1;
          send_gap = calm ? 0 : $urandom_range(0, 4);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random back-pressure, long hold-off on request, in-order check
  // --------------------------------------------------------------------------
  int recv_stall = 0;
  int hold_left = 0;
  int hold_seen = 0;

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected beat", out_ch.seg_addr, '0);
        end else begin
          want = expected_beats.pop_front();
          check_field("status", out_ch.status, want.status);
          check_field("head_id", out_ch.head_id, want.head_id);
          check_field("writable", out_ch.writable, want.writable);
          check_field("seg_addr", out_ch.seg_addr, want.seg_addr);
          check_field("seg_len", out_ch.seg_len, want.seg_len);
          check_field("in_count", out_ch.in_count, want.in_count);
          check_field("out_count", out_ch.out_count, want.out_count);
          check_field("in_total", out_ch.in_total, want.in_total);
          check_field("out_total", out_ch.out_total, want.out_total);
          check_field("count", out_ch.count, want.count);
          check_field("no_notify", out_ch.no_notify, want.no_notify);
          check_field("last", out_ch.last, want.last);
        end
        recv_stall = calm ? 0 : $urandom_range(0, 4);
      end else if (recv_stall > 0) begin
        recv_stall--;
      end
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_ch.ready <= (hold_left == 0) && (recv_stall == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  int          gen_count;
  logic [15:0] gen_avail;

  task automatic queue_cmd(cmd_e c, logic [15:0] idx, logic [63:0] addr, logic [31:0] len,
                           logic [1:0] bits, logic [15:0] nxt);
    pending_cmds.push_back('{c, idx, addr, len, bits, nxt});
    gen_count++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Hold until the block has nothing in flight, then a little longer.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_cmds.size() != 0 || in_ch.valid || expected_beats.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [8:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_ENABLE:  m_enabled = val[0];
      CFG_SIZE:    m_size = val;
      CFG_MAX_IN:  m_max_in = val[4:0];
      default:     m_max_out = val[4:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Post one buffer the way a driver would: chain, avail slot, index bump,
  // then fetch it and hand it back.
  task automatic post_buffer();
    int unsigned sz, n;
    logic [15:0] d [4];
    logic [15:0] link;
    sz = ring_span();
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) d[i] = $urandom_range(0, sz - 1);
    for (int i = 0; i < n; i++) begin
      link = (i + 1 < n) ? d[i + 1] : 16'($urandom);
      if ($urandom_range(0, 15) == 0) link = 16'($urandom);
      queue_cmd(CMD_WR_DESC, d[i], rand64(), $urandom,
                {1'($urandom), 1'(i + 1 < n)}, link);
    end
    queue_cmd(CMD_WR_AVAIL, gen_avail % sz, rand64(), $urandom, 2'($urandom), d[0]);
    gen_avail = gen_avail + 16'd1;
    queue_cmd(CMD_SET_AVAIL, gen_avail, rand64(), $urandom, 2'($urandom), 16'($urandom));
    if ($urandom_range(0, 3) == 0)
      queue_cmd(CMD_POLL, 16'($urandom), rand64(), $urandom, 2'($urandom), 16'($urandom));
    queue_cmd(CMD_FETCH, 16'($urandom), rand64(), $urandom, 2'($urandom), 16'($urandom));
    queue_cmd(CMD_RETURN, ($urandom_range(0, 7) == 0) ? 16'($urandom) : d[0], rand64(),
              $urandom, 2'($urandom), 16'($urandom));
  endtask

  // Random command with random fields; in-range used-slot reads hit only written slots.
  task automatic noise_cmd();
    cmd_e        c;
    logic [15:0] idx;
    c = cmd_e'($urandom_range(0, 7));
    idx = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 255));
    if (c == CMD_RD_USED && idx < QUEUE_DEPTH && !used_written[idx]) begin
      idx = 16'($urandom_range(QUEUE_DEPTH, 65535));
      for (int i = 0; i < QUEUE_DEPTH; i++)
        if (used_written[i] && $urandom_range(0, 3) == 0) idx = i;
    end
    queue_cmd(c, idx, rand64(), $urandom, 2'($urandom), 16'($urandom));
  endtask

  initial begin
    logic [8:0] sizes [5];
    logic [4:0] caps [5];
    in_ch.valid = 1'b0;
    in_ch.command = CMD_POLL;
    in_ch.index = '0;
    in_ch.buf_addr = '0;
    in_ch.buf_len = '0;
    in_ch.desc_bits = '0;
    in_ch.next_index = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ENABLE;
    cfg_wdata = '0;
    m_avail_idx = '0; m_seen_idx = '0; m_used_idx = '0; m_suppress = 1'b0;
    m_enabled = 1'b0; m_size = 9'd256; m_max_in = 5'd16; m_max_out = 5'd16;
    for (int i = 0; i < QUEUE_DEPTH; i++) used_written[i] = 1'b0;
    gen_avail = '0;
    gen_count = 0;

    // assert reset once, then release it
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // ring still closed after reset
    queue_cmd(CMD_FETCH, '0, '0, '0, '0, '0);
    queue_cmd(CMD_RETURN, 16'd1, '0, 32'd5, '0, '0);
    queue_cmd(CMD_SUPPRESS, '0, '0, '0, '0, '0);
    queue_cmd(CMD_POLL, '0, '0, '0, '0, '0);

    // fill every table entry so no walk touches an unwritten one
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      queue_cmd(CMD_WR_DESC, i, rand64(), $urandom, 2'($urandom), 16'($urandom_range(0, 255)));
      queue_cmd(CMD_WR_AVAIL, i, '0, '0, '0, 16'($urandom_range(0, 255)));
    end
    wait_idle();
    write_reg(CFG_ENABLE, 9'd1);

    // directed: field extremes and the error paths
    queue_cmd(CMD_WR_DESC, 16'hFFFF, '1, '1, 2'b11, 16'hFFFF);
    queue_cmd(CMD_WR_DESC, 16'd255, '1, '1, 2'b11, 16'hFFFF);  // link past ring
    queue_cmd(CMD_WR_AVAIL, 16'd256, '0, '0, '0, 16'd7);
    queue_cmd(CMD_WR_AVAIL, 16'd0, '0, '0, '0, 16'd255);
    queue_cmd(CMD_SET_AVAIL, 16'hFFFF, '0, '0, '0, '0);         // too far ahead
    queue_cmd(CMD_FETCH, '0, '0, '0, '0, '0);
    queue_cmd(CMD_SET_AVAIL, 16'd1, '0, '0, '0, '0);
    queue_cmd(CMD_POLL, '0, '0, '0, '0, '0);
    queue_cmd(CMD_FETCH, '0, '0, '0, '0, '0);
    queue_cmd(CMD_WR_AVAIL, 16'd1, '0, '0, '0, 16'd300);         // head past ring
    queue_cmd(CMD_SET_AVAIL, 16'd2, '0, '0, '0, '0);
    queue_cmd(CMD_FETCH, '0, '0, '0, '0, '0);
    queue_cmd(CMD_FETCH, '0, '0, '0, '0, '0);                    // nothing pending
    queue_cmd(CMD_RETURN, 16'd256, '0, 32'd1, '0, '0);
    queue_cmd(CMD_RETURN, 16'hFFFF, '0, 32'd1, '0, '0);
    queue_cmd(CMD_RETURN, 16'd255, '0, '1, '0, '0);
    queue_cmd(CMD_RD_USED, 16'd0, '0, '0, '0, '0);
    queue_cmd(CMD_RD_USED, 16'hFFFF, '0, '0, '0, '0);
    queue_cmd(CMD_POLL, '0, '0, '0, '0, '0);
    queue_cmd(CMD_SUPPRESS, '0, '0, '0, '0, '0);
    queue_cmd(CMD_POLL, '0, '0, '0, '0, '0);
    wait_idle();

    // random phases, each with its own register setting
    sizes = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd16};
    caps  = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd3};
    for (int p = 0; p < 10; p++) begin
      calm = (p % 3 == 0);
      write_reg(CFG_ENABLE, (p == 4) ? 9'd0 : 9'd1);
      write_reg(CFG_SIZE, (p < 5) ? sizes[p] : 9'($urandom_range(0, 511)));
      write_reg(CFG_MAX_IN, (p < 5) ? caps[p] : 9'($urandom_range(0, 31)));
      write_reg(CFG_MAX_OUT, (p < 5) ? caps[(p + 2) % 5] : 9'($urandom_range(0, 31)));
      // realign the avail index with what the block has consumed
      gen_avail = m_seen_idx;
      gen_count = 0;
      queue_cmd(CMD_SET_AVAIL, gen_avail, rand64(), $urandom, 2'($urandom), 16'($urandom));
      if (p == 2) hold_req++;   // receiver holds off while beats pile up
      while (gen_count < 41) begin
        if ($urandom_range(0, 4) == 0) noise_cmd();
        else post_buffer();
      end
      wait_idle();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_beats.size() != 0) report_mismatch("beats left over", expected_beats.size(), 0);
    if (errors == 0) begin
      $display("split_virtqueue_device_side_top_tb: clean");
    end else begin
      $display("split_virtqueue_device_side_top_tb: errors");
    end
    $finish;
  end

endmodule
